// ----- design/segment_line_split_test_defines.svh -----
// Assertion macros for the segment / splitting-line test block.
// Included by segment_line_split_test.sv, which carries concurrent checks; no other dependencies.
`ifndef SEGMENT_LINE_SPLIT_TEST_DEFINES_SVH
`define SEGMENT_LINE_SPLIT_TEST_DEFINES_SVH
`ifndef SYNTH
// Plain check, sampled on the rising clock edge, masked while in reset.
`define SLT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("segment_line_split_test check failed");
// Implication whose consequent must hold in the cycle after the antecedent.
`define SLT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment_line_split_test check failed");
`else
`define SLT_ASSERT(lbl, prop)
`define SLT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/slt_pkg.sv -----
// Shared constants for the segment / splitting-line test block.
// Holds the configuration register indices; no dependencies.
`default_nettype none
package slt_pkg;

    // Configuration port index width and register codes.
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINE_A = 2'd0,
        CFG_LINE_B = 2'd1,
        CFG_LINE_C = 2'd2
    } cfg_reg_t;

endpackage
`default_nettype wire

// ----- design/segment_line_split_test.sv -----
// Accepts one word per cycle while the output is not stalled; the quotients are
// formed one bit per stage over COORD_WIDTH + 1 stages of a restoring divider,
// each stage a wide compare and subtract for each of the two quotients. Reset
// clears the valid bits and the line registers.
// A stalled output holds the whole pipeline in place.
// Depends on slt_pkg and segment_line_split_test_defines.svh.
`default_nettype none
`include "segment_line_split_test_defines.svh"
module segment_line_split_test #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Configuration write port
    input  wire logic                                  cfg_we,
    input  wire logic [slt_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [COORD_WIDTH-1:0]                cfg_data,
    // Input channel
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [COORD_WIDTH-1:0]         start_x,
    input  wire logic signed [COORD_WIDTH-1:0]         start_y,
    input  wire logic signed [COORD_WIDTH-1:0]         end_x,
    input  wire logic signed [COORD_WIDTH-1:0]         end_y,
    // Output channel
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       crosses,
    output logic signed [COORD_WIDTH-1:0]              cross_x,
    output logic signed [COORD_WIDTH-1:0]              cross_y,
    output logic                                       start_front,
    output logic                                       end_front
);

    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int SW   = W + 1;
    localparam int P2   = 2 * W;
    localparam int PS   = 2 * W + 1;
    localparam int SCW  = 2 * W + 1;
    localparam int DTW  = 2 * W + 2;
    localparam int CSW  = 2 * W + 1 + F;
    localparam int FSA  = (2 * W + 1 > W + F) ? 2 * W + 1 : W + F;
    localparam int FSW  = FSA + 1;
    localparam int HPW  = 2 * W + 1;
    localparam int SBW  = 3 * W + 1;
    localparam int NXA  = (SBW > CSW) ? SBW : CSW;
    localparam int NXW  = NXA + 1;
    localparam int D    = W + 1;
    localparam int RWA  = (NXW > DTW + D) ? NXW : DTW + D;
    localparam int RW   = RWA + 1;
    localparam int QW   = W + 2;
    localparam int NS   = D + 9;

    typedef struct packed {
        logic signed [W-1:0] minx;
        logic signed [W-1:0] maxx;
        logic signed [W-1:0] miny;
        logic signed [W-1:0] maxy;
        logic                sfront;
        logic                efront;
        logic                det_nz;
        logic                negx;
        logic                negy;
        logic                ovfx;
        logic                ovfy;
    } side_t;

    // Pipeline advance: everything moves unless a finished word is held.
    logic adv;
    logic accept;
    logic [NS-1:0] vld_reg;

    assign adv      = !(vld_reg[NS-1] && out_stall);
    assign in_stall = !adv;
    assign accept   = in_valid && !in_stall;

    // Configuration registers.
    logic signed [W-1:0] line_a_reg;
    logic signed [W-1:0] line_b_reg;
    logic signed [W-1:0] line_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_a_reg <= '0;
            line_b_reg <= '0;
            line_c_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                slt_pkg::CFG_LINE_A: line_a_reg <= cfg_data;
                slt_pkg::CFG_LINE_B: line_b_reg <= cfg_data;
                slt_pkg::CFG_LINE_C: line_c_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], accept};
    end

    // Stage 1: register endpoints, segment direction and bounding box.
    logic signed [W-1:0]  x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [SW-1:0] sa_reg, sb_reg;
    side_t                s1_next, s1_reg;

    always_comb
    begin
        s1_next        = '0;
        s1_next.minx   = (start_x < end_x) ? start_x : end_x;
        s1_next.maxx   = (start_x < end_x) ? end_x : start_x;
        s1_next.miny   = (start_y < end_y) ? start_y : end_y;
        s1_next.maxy   = (start_y < end_y) ? end_y : start_y;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg <= start_x;
            y1_reg <= start_y;
            x2_reg <= end_x;
            y2_reg <= end_y;
            sa_reg <= SW'(end_y) - SW'(start_y);
            sb_reg <= SW'(start_x) - SW'(end_x);
            s1_reg <= s1_next;
        end
    end

    // Stage 2: all first-level products.
    logic signed [P2-1:0] p_x2y1_reg, p_x1y2_reg;
    logic signed [P2-1:0] p_ax1_reg, p_by1_reg, p_ax2_reg, p_by2_reg;
    logic signed [PS-1:0] p_asb_reg, p_bsa_reg, p_csb_reg, p_csa_reg;
    side_t                s2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_x2y1_reg <= P2'(x2_reg) * P2'(y1_reg);
            p_x1y2_reg <= P2'(x1_reg) * P2'(y2_reg);
            p_ax1_reg  <= P2'(line_a_reg) * P2'(x1_reg);
            p_by1_reg  <= P2'(line_b_reg) * P2'(y1_reg);
            p_ax2_reg  <= P2'(line_a_reg) * P2'(x2_reg);
            p_by2_reg  <= P2'(line_b_reg) * P2'(y2_reg);
            p_asb_reg  <= PS'(line_a_reg) * PS'(sb_reg);
            p_bsa_reg  <= PS'(line_b_reg) * PS'(sa_reg);
            p_csb_reg  <= PS'(line_c_reg) * PS'(sb_reg);
            p_csa_reg  <= PS'(line_c_reg) * PS'(sa_reg);
            s2_reg     <= s1_reg;
        end
    end

    // Stage 3: segment constant, determinant and endpoint sides.
    logic signed [SCW-1:0] sc_reg;
    logic signed [DTW-1:0] det_reg;
    logic signed [CSW-1:0] csb_reg, csa_reg;
    logic signed [FSW-1:0] fs1, fs2;
    side_t                 s3_next, s3_reg;

    always_comb
    begin
        fs1 = FSW'(p_ax1_reg) + FSW'(p_by1_reg) + (FSW'(line_c_reg) <<< F);
        fs2 = FSW'(p_ax2_reg) + FSW'(p_by2_reg) + (FSW'(line_c_reg) <<< F);
        s3_next        = s2_reg;
        s3_next.sfront = !fs1[FSW-1] && (fs1 != '0);
        s3_next.efront = !fs2[FSW-1] && (fs2 != '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_reg  <= SCW'(p_x2y1_reg) - SCW'(p_x1y2_reg);
            det_reg <= DTW'(p_asb_reg) - DTW'(p_bsa_reg);
            csb_reg <= CSW'(p_csb_reg) <<< F;
            csa_reg <= CSW'(p_csa_reg) <<< F;
            s3_reg  <= s3_next;
        end
    end

    // Stage 4: segment constant times line coefficients, in two halves.
    logic signed [W:0]     sc_lo, sc_hi;
    logic signed [HPW-1:0] lo_b_reg, hi_b_reg, lo_a_reg, hi_a_reg;
    logic signed [DTW-1:0] det4_reg;
    logic signed [CSW-1:0] csb4_reg, csa4_reg;
    side_t                 s4_reg;

    assign sc_lo = signed'({1'b0, sc_reg[W-1:0]});
    assign sc_hi = signed'(sc_reg[SCW-1:W]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_b_reg <= HPW'(sc_lo) * HPW'(line_b_reg);
            hi_b_reg <= HPW'(sc_hi) * HPW'(line_b_reg);
            lo_a_reg <= HPW'(sc_lo) * HPW'(line_a_reg);
            hi_a_reg <= HPW'(sc_hi) * HPW'(line_a_reg);
            det4_reg <= det_reg;
            csb4_reg <= csb_reg;
            csa4_reg <= csa_reg;
            s4_reg   <= s3_reg;
        end
    end

    // Stage 5: recombine the half products.
    logic signed [SBW-1:0] scb_reg, sca_reg;
    logic signed [DTW-1:0] det5_reg;
    logic signed [CSW-1:0] csb5_reg, csa5_reg;
    side_t                 s5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            scb_reg  <= (SBW'(hi_b_reg) <<< W) + SBW'(lo_b_reg);
            sca_reg  <= (SBW'(hi_a_reg) <<< W) + SBW'(lo_a_reg);
            det5_reg <= det4_reg;
            csb5_reg <= csb4_reg;
            csa5_reg <= csa4_reg;
            s5_reg   <= s4_reg;
        end
    end

    // Stage 6: Cramer numerators.
    logic signed [NXW-1:0] nx_reg, ny_reg;
    logic signed [DTW-1:0] det6_reg;
    side_t                 s6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg   <= NXW'(scb_reg) - NXW'(csb5_reg);
            ny_reg   <= NXW'(csa5_reg) - NXW'(sca_reg);
            det6_reg <= det5_reg;
            s6_reg   <= s5_reg;
        end
    end

    // Stage 7: magnitudes and quotient signs.
    logic [NXW-1:0] nmx_reg, nmy_reg;
    logic [DTW-1:0] dm7_reg;
    side_t          s7_next, s7_reg;

    always_comb
    begin
        s7_next        = s6_reg;
        s7_next.det_nz = (det6_reg != '0);
        s7_next.negx   = nx_reg[NXW-1] ^ det6_reg[DTW-1];
        s7_next.negy   = ny_reg[NXW-1] ^ det6_reg[DTW-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nmx_reg <= nx_reg[NXW-1] ? NXW'(-nx_reg) : NXW'(nx_reg);
            nmy_reg <= ny_reg[NXW-1] ? NXW'(-ny_reg) : NXW'(ny_reg);
            dm7_reg <= det6_reg[DTW-1] ? DTW'(-det6_reg) : DTW'(det6_reg);
            s7_reg  <= s7_next;
        end
    end

    // Divider entry: flag quotients too large for the coordinate range.
    logic [RW-1:0]  rx_reg [0:D];
    logic [RW-1:0]  ry_reg [0:D];
    logic [D-1:0]   qx_reg [0:D];
    logic [D-1:0]   qy_reg [0:D];
    logic [DTW-1:0] dm_reg [0:D];
    side_t          sd_reg [0:D];
    logic [RW-1:0]  dlim;
    side_t          s8_next;

    always_comb
    begin
        dlim         = RW'(dm7_reg) << D;
        s8_next      = s7_reg;
        s8_next.ovfx = (RW'(nmx_reg) >= dlim);
        s8_next.ovfy = (RW'(nmy_reg) >= dlim);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg[0] <= RW'(nmx_reg);
            ry_reg[0] <= RW'(nmy_reg);
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            dm_reg[0] <= dm7_reg;
            sd_reg[0] <= s8_next;
        end
    end

    // Restoring divider: one quotient bit per stage, most significant first.
    logic [RW-1:0] tx_c [0:D-1];
    logic          gx_c [0:D-1];
    logic          gy_c [0:D-1];

    always_comb
    begin
        for (int j = 0; j < D; j++)
        begin
            tx_c[j] = RW'(dm_reg[j]) << (W - j);
            gx_c[j] = (rx_reg[j] >= tx_c[j]);
            gy_c[j] = (ry_reg[j] >= tx_c[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < D; j++)
            begin
                rx_reg[j+1] <= gx_c[j] ? rx_reg[j] - tx_c[j] : rx_reg[j];
                ry_reg[j+1] <= gy_c[j] ? ry_reg[j] - tx_c[j] : ry_reg[j];
                qx_reg[j+1] <= {qx_reg[j][D-2:0], gx_c[j]};
                qy_reg[j+1] <= {qy_reg[j][D-2:0], gy_c[j]};
                dm_reg[j+1] <= dm_reg[j];
                sd_reg[j+1] <= sd_reg[j];
            end
        end
    end

    // Final stage: signed quotients, bounding-box test and output word.
    logic signed [QW-1:0] qex, qey, qsx, qsy;
    logic                 in_box, hit;
    side_t                sf;
    logic                 crosses_reg, start_front_reg, end_front_reg;
    logic signed [W-1:0]  cross_x_reg, cross_y_reg;

    always_comb
    begin
        sf     = sd_reg[D];
        qex    = signed'({1'b0, qx_reg[D]});
        qey    = signed'({1'b0, qy_reg[D]});
        qsx    = sf.negx ? -qex : qex;
        qsy    = sf.negy ? -qey : qey;
        in_box = (qsx >= QW'(sf.minx)) && (qsx <= QW'(sf.maxx))
              && (qsy >= QW'(sf.miny)) && (qsy <= QW'(sf.maxy));
        hit    = sf.det_nz && !sf.ovfx && !sf.ovfy && in_box;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            crosses_reg     <= hit;
            cross_x_reg     <= hit ? qsx[W-1:0] : '0;
            cross_y_reg     <= hit ? qsy[W-1:0] : '0;
            start_front_reg <= sf.sfront;
            end_front_reg   <= sf.efront;
        end
    end

    assign out_valid   = vld_reg[NS-1];
    assign crosses     = crosses_reg;
    assign cross_x     = cross_x_reg;
    assign cross_y     = cross_y_reg;
    assign start_front = start_front_reg;
    assign end_front   = end_front_reg;

    // Checks on the pipeline control and the result word.
    `SLT_ASSERT(a_no_cross_zero, out_valid && !crosses_reg |-> cross_x_reg == '0 && cross_y_reg == '0)
    `SLT_ASSERT_NEXT(a_stall_freezes, out_valid && out_stall, out_valid && $stable(vld_reg))
    `SLT_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld_reg[0])

endmodule
`default_nettype wire
